>>> sv/fbs_pkg.sv
// Shared types, constants and helpers for the palette framebuffer scan-out block.
// Used by fbs_palette and palette_framebuffer_scanout; depends on nothing else.
package fbs_pkg;

    // Store and window geometry.
    localparam int STORE_ROWS = 256;
    localparam int STORE_COLS = 128;
    localparam int VIEW_ROWS  = 128;
    localparam int VIEW_COLS  = 128;
    localparam int BLOCK_ROWS = 8;
    localparam int BLOCK_COLS = 8;

    localparam int ROW_W      = $clog2(STORE_ROWS);
    localparam int COL_W      = $clog2(STORE_COLS);
    localparam int ROW_SUM_W  = ROW_W + 2;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int STORE_DEPTH = STORE_ROWS * STORE_COLS;
    localparam int SCAN_R_W   = (VIEW_ROWS > 1) ? $clog2(VIEW_ROWS) : 1;
    localparam int SCAN_C_W   = (VIEW_COLS > 1) ? $clog2(VIEW_COLS) : 1;
    localparam int BLK_R_W    = (BLOCK_ROWS > 1) ? $clog2(BLOCK_ROWS) : 1;
    localparam int BLK_C_W    = (BLOCK_COLS > 1) ? $clog2(BLOCK_COLS) : 1;

    // Item and beat field widths.
    localparam int ACT_W   = 2;
    localparam int PX_W    = 7;
    localparam int PY_W    = 8;
    localparam int CELL_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 16;

    // Palette.
    localparam int NPAL      = 7;
    localparam int PAL_IDX_W = 3;
    localparam logic [COLOR_W-1:0] PAL_RESET [NPAL] = '{
        16'h0000, 16'h0821, 16'h1863, 16'h38E7, 16'h79EF, 16'hFBFF, 16'hFFFF
    };

    // Window setup sequence.
    localparam int SETUP_LEN = 7;
    localparam int STEP_W    = 3;
    localparam logic [BYTE_W-1:0] CMD_COL_ADDR = 8'h15;
    localparam logic [BYTE_W-1:0] CMD_ROW_ADDR = 8'h75;
    localparam logic [BYTE_W-1:0] CMD_WR_RAM   = 8'h5C;
    localparam logic [BYTE_W-1:0] WIN_START    = 8'h00;
    localparam logic [BYTE_W-1:0] WIN_END      = 8'h7F;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_BEGIN = 2'd1,
        ACT_PIXEL = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_PIX_LO,
        ST_PIX_HI
    } t_state;

    // Byte and command flag of one step of the setup sequence.
    function automatic logic [BYTE_W:0] setup_beat(input logic [STEP_W-1:0] step);
        logic [BYTE_W:0] beat;
        case (step)
            3'd0:    beat = {1'b1, CMD_COL_ADDR};
            3'd1:    beat = {1'b0, WIN_START};
            3'd2:    beat = {1'b0, WIN_END};
            3'd3:    beat = {1'b1, CMD_ROW_ADDR};
            3'd4:    beat = {1'b0, WIN_START};
            3'd5:    beat = {1'b0, WIN_END};
            default: beat = {1'b1, CMD_WR_RAM};
        endcase
        return beat;
    endfunction

    // Row sums stay below three times the store height, so two
    // conditional subtractions bring them back into range.
    function automatic logic [ROW_W-1:0] wrap_row(input logic [ROW_SUM_W-1:0] sum);
        logic [ROW_SUM_W-1:0] s1;
        logic [ROW_SUM_W-1:0] s2;
        s1 = (sum >= ROW_SUM_W'(STORE_ROWS)) ? sum - ROW_SUM_W'(STORE_ROWS) : sum;
        s2 = (s1 >= ROW_SUM_W'(STORE_ROWS)) ? s1 - ROW_SUM_W'(STORE_ROWS) : s1;
        return s2[ROW_W-1:0];
    endfunction

endpackage

>>> sv/palette_framebuffer_scanout.sv
// Indexed-color framebuffer with scrolling scan-out toward a serial panel.
// Top level: control sequencer, index store and output register.
// Depends on fbs_pkg, fbs_ram and fbs_palette.
//
// After reset the block clears its 32768-entry index store, one entry per
// cycle, and accepts no item until the clear is done (palette writes are
// taken at any time). A write item gives no beat. A pixel item reads the
// store, which answers in the next cycle, then sends its low and high color
// bytes; the one-byte output channel limits the sustained pixel rate, though
// the next item is taken while the high byte is loaded. A begin item sends
// seven setup beats, one per cycle while the output takes them. An output
// register holds the last beat, so stalls on the output side only hold the
// sequencer where a beat is waiting to be loaded.
module palette_framebuffer_scanout (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input items.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // pos_x [6:0], pos_y [14:7], cell_value [17:15], block_restart [18], zero pad [23:19]
    input  logic [23:0]                     i_s_tdata,
    // action [1:0]
    input  logic [fbs_pkg::ACT_W-1:0]       i_s_tuser,
    // Panel bytes.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_byte [7:0]
    output logic [fbs_pkg::BYTE_W-1:0]      o_m_tdata,
    // is_command [0], frame_done [1]
    output logic [1:0]                      o_m_tuser,
    // last_of_run
    output logic                            o_m_tlast,
    // Palette configuration.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fbs_pkg::PAL_IDX_W-1:0]   i_cfg_index,
    input  logic [fbs_pkg::COLOR_W-1:0]     i_cfg_data
);
    import fbs_pkg::*;

    // Unpacked input fields.
    logic [PX_W-1:0]   in_px;
    logic [PY_W-1:0]   in_py;
    logic [CELL_W-1:0] in_cell;
    logic              in_restart;
    logic              in_acc;
    logic              slot_free;

    assign in_px      = i_s_tdata[PX_W-1:0];
    assign in_py      = i_s_tdata[PX_W+PY_W-1:PX_W];
    assign in_cell    = i_s_tdata[PX_W+PY_W+CELL_W-1:PX_W+PY_W];
    assign in_restart = i_s_tdata[PX_W+PY_W+CELL_W];

    // Control state.
    t_state              r_state,    n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [STEP_W-1:0]   r_step,     n_step;
    logic [BLK_R_W-1:0]  r_blk_r,    n_blk_r;
    logic [BLK_C_W-1:0]  r_blk_c,    n_blk_c;
    logic [PX_W-1:0]     r_org_c,    n_org_c;
    logic [PY_W-1:0]     r_org_r,    n_org_r;
    logic [SCAN_R_W-1:0] r_scan_r,   n_scan_r;
    logic [SCAN_C_W-1:0] r_scan_c,   n_scan_c;
    logic                r_active,   n_active;
    logic                r_done,     n_done;

    // Output register.
    logic                r_m_valid,  n_m_valid;
    logic [BYTE_W-1:0]   r_m_byte,   n_m_byte;
    logic                r_m_cmd,    n_m_cmd;
    logic                r_m_last,   n_m_last;
    logic                r_m_done,   n_m_done;

    // Store access.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;
    logic [COLOR_W-1:0]  color;

    // Scratch for address and counter math.
    logic [BLK_R_W-1:0]  blk_r;
    logic [BLK_C_W-1:0]  blk_c;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                pix_last;
    logic [BYTE_W:0]     setup;

    fbs_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (CELL_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fbs_palette u_palette (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_index     (ram_rdata),
        .o_color     (color)
    );

    assign slot_free  = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) || (r_state == ST_PIX_HI && slot_free);
    assign in_acc     = i_s_tvalid && o_s_tready;

    assign o_m_tvalid   = r_m_valid;
    assign o_m_tdata    = r_m_byte;
    assign o_m_tuser[0] = r_m_cmd;
    assign o_m_tuser[1] = r_m_done;
    assign o_m_tlast    = r_m_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_step     <= '0;
            r_blk_r    <= '0;
            r_blk_c    <= '0;
            r_org_c    <= '0;
            r_org_r    <= '0;
            r_scan_r   <= '0;
            r_scan_c   <= '0;
            r_active   <= 1'b0;
            r_done     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_step     <= n_step;
            r_blk_r    <= n_blk_r;
            r_blk_c    <= n_blk_c;
            r_org_c    <= n_org_c;
            r_org_r    <= n_org_r;
            r_scan_r   <= n_scan_r;
            r_scan_c   <= n_scan_c;
            r_active   <= n_active;
            r_done     <= n_done;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_byte <= n_m_byte;
        r_m_cmd  <= n_m_cmd;
        r_m_last <= n_m_last;
        r_m_done <= n_m_done;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_step     = r_step;
        n_blk_r    = r_blk_r;
        n_blk_c    = r_blk_c;
        n_org_c    = r_org_c;
        n_org_r    = r_org_r;
        n_scan_r   = r_scan_r;
        n_scan_c   = r_scan_c;
        n_active   = r_active;
        n_done     = r_done;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_byte   = r_m_byte;
        n_m_cmd    = r_m_cmd;
        n_m_last   = r_m_last;
        n_m_done   = r_m_done;
        ram_we     = 1'b0;
        ram_waddr  = r_clr_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        blk_r      = in_restart ? '0 : r_blk_r;
        blk_c      = in_restart ? '0 : r_blk_c;
        row        = '0;
        col        = '0;
        pix_last   = (r_scan_r == SCAN_R_W'(VIEW_ROWS - 1))
                  && (r_scan_c == SCAN_C_W'(VIEW_COLS - 1));
        setup      = setup_beat(r_step);

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SETUP: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_byte  = setup[BYTE_W-1:0];
                    n_m_cmd   = setup[BYTE_W];
                    n_m_last  = (r_step == STEP_W'(SETUP_LEN - 1));
                    n_m_done  = 1'b0;
                    n_step    = r_step + 1'b1;
                    if (r_step == STEP_W'(SETUP_LEN - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PIX_LO: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_byte  = color[BYTE_W-1:0];
                    n_m_cmd   = 1'b0;
                    n_m_last  = 1'b0;
                    n_m_done  = r_done;
                    n_state   = ST_PIX_HI;
                end
            end
            ST_PIX_HI: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_byte  = color[2*BYTE_W-1:BYTE_W];
                    n_m_cmd   = 1'b0;
                    n_m_last  = 1'b1;
                    n_m_done  = r_done;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
            end
        endcase

        // An accepted item may override the next state chosen above; the
        // high byte of the previous pixel is already loaded in that cycle.
        if (in_acc) begin
            case (i_s_tuser)
                ACT_WRITE: begin
                    row       = wrap_row(ROW_SUM_W'(in_py) + ROW_SUM_W'(blk_r));
                    col       = COL_W'(in_px) + COL_W'(blk_c);
                    ram_we    = 1'b1;
                    ram_waddr = {row, col};
                    ram_wdata = in_cell;
                    if (blk_c == BLK_C_W'(BLOCK_COLS - 1)) begin
                        n_blk_c = '0;
                        n_blk_r = (blk_r == BLK_R_W'(BLOCK_ROWS - 1)) ? '0 : blk_r + 1'b1;
                    end else begin
                        n_blk_c = blk_c + 1'b1;
                        n_blk_r = blk_r;
                    end
                    n_state = ST_IDLE;
                end
                ACT_BEGIN: begin
                    n_org_c  = in_px;
                    n_org_r  = in_py;
                    n_scan_r = '0;
                    n_scan_c = '0;
                    n_active = 1'b1;
                    n_step   = '0;
                    n_state  = ST_SETUP;
                end
                ACT_PIXEL: begin
                    if (r_active) begin
                        row       = wrap_row(ROW_SUM_W'(r_org_r) + ROW_SUM_W'(r_scan_r));
                        col       = COL_W'(r_org_c) + COL_W'(r_scan_c);
                        ram_re    = 1'b1;
                        ram_raddr = {row, col};
                        n_done    = pix_last;
                        if (pix_last) begin
                            n_active = 1'b0;
                            n_scan_r = '0;
                            n_scan_c = '0;
                        end else if (r_scan_c == SCAN_C_W'(VIEW_COLS - 1)) begin
                            n_scan_c = '0;
                            n_scan_r = r_scan_r + 1'b1;
                        end else begin
                            n_scan_c = r_scan_c + 1'b1;
                        end
                        n_state = ST_PIX_LO;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/fbs_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. Generic; no dependencies.
module fbs_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 3
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fbs_palette.sv
// Palette register file with its configuration write port and the index
// to RGB565 lookup. Depends on fbs_pkg.
module fbs_palette (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fbs_pkg::PAL_IDX_W-1:0]    i_cfg_index,
    input  logic [fbs_pkg::COLOR_W-1:0]      i_cfg_data,
    input  logic [fbs_pkg::CELL_W-1:0]       i_index,
    output logic [fbs_pkg::COLOR_W-1:0]      o_color
);
    import fbs_pkg::*;

    logic [COLOR_W-1:0]   r_pal [NPAL];
    logic [PAL_IDX_W-1:0] sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal <= PAL_RESET;
        end else if (i_cfg_valid && i_cfg_index < PAL_IDX_W'(NPAL)) begin
            r_pal[i_cfg_index] <= i_cfg_data;
        end
    end

    // Index 7 has no entry of its own and shares the last one.
    always_comb begin
        sel = (i_index > CELL_W'(NPAL - 1)) ? PAL_IDX_W'(NPAL - 1) : PAL_IDX_W'(i_index);
        o_color = r_pal[sel];
    end

endmodule

>>> tb/sv/tb_palette_framebuffer_scanout.sv
`timescale 1ns / 100ps
// Self-checking testbench for palette_framebuffer_scanout: drives block writes, frame
// begins and pixel items, predicts every panel byte and checks each output beat.
// Depends on fbs_pkg and the palette_framebuffer_scanout RTL.
module tb_palette_framebuffer_scanout;
    import fbs_pkg::*;

    localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;
    localparam int CELLS_PER_BLOCK = BLOCK_ROWS * BLOCK_COLS;
    localparam int CYCLE_LIMIT = 5_000_000;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [PX_W-1:0]   px;
        logic [PY_W-1:0]   py;
        logic [CELL_W-1:0] cidx;
        logic              restart;
        int                gap;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              cmd;
        logic              last;
        logic              done;
    } t_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [23:0]           i_s_tdata = '0;
    logic [ACT_W-1:0]      i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [BYTE_W-1:0]     o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [PAL_IDX_W-1:0]  i_cfg_index = '0;
    logic [COLOR_W-1:0]    i_cfg_data = '0;

    palette_framebuffer_scanout u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted copy of the block's state.
    logic [CELL_W-1:0]  idx_store [STORE_DEPTH];
    logic [COLOR_W-1:0] pal_model [NPAL] = '{
        16'h0000, 16'h0821, 16'h1863, 16'h38E7, 16'h79EF, 16'hFBFF, 16'hFFFF
    };
    logic [BYTE_W:0] setup_seq [SETUP_LEN] = '{
        {1'b1, CMD_COL_ADDR}, {1'b0, WIN_START}, {1'b0, WIN_END},
        {1'b1, CMD_ROW_ADDR}, {1'b0, WIN_START}, {1'b0, WIN_END},
        {1'b1, CMD_WR_RAM}
    };
    int cell_cnt = 0;
    int org_col = 0;
    int org_row = 0;
    int scan_r = 0;
    int scan_c = 0;
    bit frame_on = 1'b0;

    t_item item_q[$];
    t_beat panel_bytes_q[$];
    t_item cur_item;
    bit    staged = 1'b0;
    int    src_gap = 0;
    int    gap_odds = 4;
    bit    tail_quiet = 1'b0;
    int    snk_gap = 0;
    int    snk_mode = 1;
    int    snk_tick = 0;
    int    fail_count = 0;
    int    cycle_cnt = 0;

    function automatic int store_addr(input int row, input int col);
        return (row % STORE_ROWS) * STORE_COLS + (col % STORE_COLS);
    endfunction

    task automatic report_fail(input string msg);
        if (fail_count < 10)
            $display("[%0t] %s", $realtime, msg);
        fail_count++;
    endtask

    // Works out the panel bytes that one accepted item causes.
    task automatic predict_panel_bytes(input t_item it);
        int r;
        int c;
        int ix;
        logic [COLOR_W-1:0] color;
        logic done;
        case (it.act)
            ACT_WRITE: begin
                if (it.restart || cell_cnt >= CELLS_PER_BLOCK)
                    cell_cnt = 0;
                r = cell_cnt / BLOCK_COLS;
                c = cell_cnt % BLOCK_COLS;
                idx_store[store_addr(int'(it.py) + r, int'(it.px) + c)] = it.cidx;
                cell_cnt = (cell_cnt + 1) % CELLS_PER_BLOCK;
            end
            ACT_BEGIN: begin
                org_col = int'(it.px);
                org_row = int'(it.py);
                scan_r = 0;
                scan_c = 0;
                frame_on = 1'b1;
                for (int k = 0; k < SETUP_LEN; k++)
                    panel_bytes_q.push_back({setup_seq[k][BYTE_W-1:0], setup_seq[k][BYTE_W],
                                             k == SETUP_LEN - 1, 1'b0});
            end
            ACT_PIXEL: begin
                if (frame_on) begin
                    ix = int'(idx_store[store_addr(org_row + scan_r, org_col + scan_c)]);
                    // Index seven shares the last palette entry.
                    if (ix > NPAL - 1)
                        ix = NPAL - 1;
                    color = pal_model[ix];
                    done = (scan_r == VIEW_ROWS - 1) && (scan_c == VIEW_COLS - 1);
                    panel_bytes_q.push_back({color[7:0], 1'b0, 1'b0, done});
                    panel_bytes_q.push_back({color[15:8], 1'b0, 1'b1, done});
                    if (done) begin
                        frame_on = 1'b0;
                        scan_r = 0;
                        scan_c = 0;
                    end else begin
                        scan_c++;
                        if (scan_c >= VIEW_COLS) begin
                            scan_c = 0;
                            scan_r++;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Input driver: each staged item first waits out its own gap.
    always @(posedge i_clk) begin : drive_items
        logic v_next;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            v_next = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                predict_panel_bytes(cur_item);
                v_next = 1'b0;
            end
            if (!v_next) begin
                if (!staged && item_q.size() != 0) begin
                    cur_item = item_q.pop_front();
                    src_gap = cur_item.gap;
                    staged = 1'b1;
                end
                if (staged) begin
                    if (src_gap > 0) begin
                        src_gap--;
                    end else begin
                        i_s_tdata <= {5'd0, cur_item.restart, cur_item.cidx,
                                      cur_item.py, cur_item.px};
                        i_s_tuser <= cur_item.act;
                        v_next = 1'b1;
                        staged = 1'b0;
                    end
                end
            end
            i_s_tvalid <= v_next;
        end
    end

    // Output monitor with random back-pressure under a randomly redrawn stall mode.
    always @(posedge i_clk) begin : check_beats
        t_beat exp_beat;
        logic rdy;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (panel_bytes_q.size() == 0) begin
                    report_fail($sformatf("unexpected beat: byte %02h cmd %0d last %0d done %0d",
                                          o_m_tdata, o_m_tuser[0], o_m_tlast, o_m_tuser[1]));
                end else begin
                    exp_beat = panel_bytes_q.pop_front();
                    if (o_m_tdata !== exp_beat.data || o_m_tuser[0] !== exp_beat.cmd ||
                        o_m_tlast !== exp_beat.last || o_m_tuser[1] !== exp_beat.done)
                        report_fail($sformatf({"mismatch: expected byte %02h cmd %0d last %0d ",
                                               "done %0d, got byte %02h cmd %0d last %0d done %0d"},
                                              exp_beat.data, exp_beat.cmd, exp_beat.last,
                                              exp_beat.done, o_m_tdata, o_m_tuser[0],
                                              o_m_tlast, o_m_tuser[1]));
                end
            end
            snk_tick++;
            if (snk_tick % 256 == 0)
                snk_mode = tail_quiet ? 0 : $urandom_range(0, 2);
            if (snk_gap > 0) begin
                snk_gap--;
                rdy = 1'b0;
            end else if (snk_mode != 0 && !tail_quiet && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(1, 7) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_m_tready <= rdy;
        end
    end

    function automatic int pick_gap();
        if (tail_quiet || gap_odds == 0)
            return 0;
        return ($urandom_range(0, gap_odds - 1) == 0) ? $urandom_range(1, 7) : 0;
    endfunction

    task automatic queue_item(input logic [ACT_W-1:0] act, input int x, input int y,
                              input int v, input bit rs);
        t_item it;
        it.act = act;
        it.px = PX_W'(x);
        it.py = PY_W'(y);
        it.cidx = CELL_W'(v);
        it.restart = rs;
        it.gap = pick_gap();
        item_q.push_back(it);
    endtask

    task automatic queue_random(input logic [ACT_W-1:0] act);
        queue_item(act, $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 7),
                   $urandom_range(0, 1) == 1);
    endtask

    task automatic write_palette(input int idx, input logic [COLOR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= PAL_IDX_W'(idx);
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx < NPAL)
            pal_model[idx] = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Waits for all items to go in and all beats to come out, then lets a last write
    // item finish before the caller touches the palette.
    task automatic wait_idle();
        while (item_q.size() != 0 || staged || i_s_tvalid)
            @(posedge i_clk);
        while (panel_bytes_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Mostly frames with pixels and interleaved block writes, plus block fills and noise.
    task automatic run_random(input int n);
        int made;
        int k;
        int x;
        int y;
        int pick;
        made = 0;
        while (made < n) begin
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                queue_random(ACT_BEGIN);
                k = $urandom_range(1, 30);
                for (int j = 0; j < k; j++) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_item(ACT_WRITE, $urandom_range(0, 127), $urandom_range(0, 255),
                                   $urandom_range(0, 7), $urandom_range(0, 7) == 0);
                    else
                        queue_random(ACT_PIXEL);
                end
                made += k + 1;
            end else if (pick <= 7) begin
                x = $urandom_range(0, 127);
                y = $urandom_range(0, 255);
                k = $urandom_range(1, 70);
                for (int j = 0; j < k; j++)
                    queue_item(ACT_WRITE, x, y, $urandom_range(0, 7), j == 0);
                made += k;
            end else if (pick == 8) begin
                queue_random(ACT_PIXEL);
                made++;
            end else begin
                queue_random(ACT_NOP);
            end
        end
    endtask

    initial begin : stimulus
        foreach (idx_store[i])
            idx_store[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset palette: idle pixel, unused action, block writes
        // wrapping at the store corner, a frame that wraps, a write mid-frame and a restart.
        gap_odds = 3;
        queue_item(ACT_PIXEL, 5, 9, 3, 1'b1);
        queue_item(ACT_NOP, 127, 255, 7, 1'b1);
        queue_item(ACT_WRITE, 127, 255, 7, 1'b1);
        queue_item(ACT_WRITE, 127, 255, 5, 1'b0);
        queue_item(ACT_WRITE, 127, 255, 1, 1'b0);
        queue_item(ACT_BEGIN, 127, 255, 0, 1'b0);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_PIXEL, 127, 255, 7, 1'b1);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_WRITE, 2, 255, 4, 1'b1);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_BEGIN, 0, 0, 7, 1'b1);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_WRITE, 0, 0, 2, 1'b1);
        queue_item(ACT_WRITE, 0, 0, 3, 1'b0);
        queue_item(ACT_WRITE, 0, 0, 6, 1'b0);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        queue_item(ACT_PIXEL, 0, 0, 0, 1'b0);
        wait_idle();

        // Alternate the extremes across the palette; index seven must be ignored.
        for (int i = 0; i < NPAL; i++)
            write_palette(i, (i % 2 == 0) ? 16'hFFFF : 16'h0000);
        write_palette(NPAL, 16'h1234);
        run_random(170);
        wait_idle();

        for (int i = 0; i < NPAL; i++)
            write_palette(i, (i % 2 == 0) ? 16'h0000 : 16'hFFFF);
        write_palette(NPAL, 16'hEDCB);
        run_random(130);
        wait_idle();
        tail_quiet = 1'b1;
        run_random(50);
        wait_idle();
        repeat (16) @(posedge i_clk);

        if (panel_bytes_q.size() != 0)
            report_fail($sformatf("%0d expected beats never arrived", panel_bytes_q.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> palette_framebuffer_scanout.f
sv/fbs_pkg.sv
sv/fbs_ram.sv
sv/fbs_palette.sv
sv/palette_framebuffer_scanout.sv
tb/sv/tb_palette_framebuffer_scanout.sv
